/* design/ttiab_pkg.sv */
// ttiab_pkg: shared types and constants for the text-to-integer unit.
// Holds the character classes, the parse phases, the queue entry and the
// register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttiab_pkg;

  // Register map of the configuration channel
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN  = 2'd2;

  localparam int CFG_DATA_W  = 64;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int ALPHA_SLOTS = 16;
  localparam int DIGIT_W     = 4;

  // Reset alphabet: "0123456789"
  localparam logic [CFG_DATA_W-1:0] RST_BASE_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RST_BASE_HIGH = 64'h0000_0000_0000_3938;
  localparam logic [LEN_W-1:0]      RST_BASE_LEN  = 5'd10;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_WS,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    PH_WS,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  // One classified character as it travels from front to back.
  // hit: character is in the used alphabet, whatever its class.
  typedef struct packed {
    cls_t                 cls;
    logic                 hit;
    logic [DIGIT_W-1:0]   digit;
    logic [LEN_W-1:0]     len;
    logic                 base_ok;
  } entry_t;

endpackage

`default_nettype wire

/* design/ttiab_if.sv */
// ttiab_if: valid/ready channel interfaces of the text-to-integer unit.
// Depends on ttiab_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ttiab_in_if;
  logic                            valid;
  logic                            ready;
  logic [ttiab_pkg::CHAR_W-1:0]    ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ttiab_out_if #(parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         base_ok;
  modport source (output valid, output value, output base_ok, input ready);
  modport sink   (input valid, input value, input base_ok, output ready);
endinterface

interface ttiab_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ttiab_pkg::CFG_IDX_W-1:0]     index;
  logic [ttiab_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/ttiab_front.sv */
// ttiab_front: alphabet registers and per-character classification.
// Depends on ttiab_pkg and ttiab_if.
`timescale 1ns / 1ps
`default_nettype none

module ttiab_front #(
  parameter int MAX_BASE_CHARS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ttiab_in_if.sink                in_chan,
  ttiab_cfg_if.sink               cfg_chan,
  input  wire logic               q_full,
  output logic                    push,
  output ttiab_pkg::entry_t       push_entry
);

  logic [ttiab_pkg::CFG_DATA_W-1:0] base_low_r, base_low_nxt;
  logic [ttiab_pkg::CFG_DATA_W-1:0] base_high_r, base_high_nxt;
  logic [ttiab_pkg::LEN_W-1:0]      base_len_r, base_len_nxt;

  logic [ttiab_pkg::CHAR_W-1:0] alpha [ttiab_pkg::ALPHA_SLOTS];
  logic [ttiab_pkg::LEN_W-1:0]  used_len;
  logic                         base_ok;
  logic                         hit;
  logic [ttiab_pkg::DIGIT_W-1:0] digit;
  logic [ttiab_pkg::CHAR_W-1:0] ch;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_full;
  assign push           = in_chan.valid && !q_full;
  assign ch             = in_chan.ch;

  always_comb begin
    base_low_nxt  = base_low_r;
    base_high_nxt = base_high_r;
    base_len_nxt  = base_len_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        ttiab_pkg::CFG_BASE_LOW:  base_low_nxt  = cfg_chan.data;
        ttiab_pkg::CFG_BASE_HIGH: base_high_nxt = cfg_chan.data;
        ttiab_pkg::CFG_BASE_LEN:  base_len_nxt  = cfg_chan.data[ttiab_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_low_r  <= ttiab_pkg::RST_BASE_LOW;
      base_high_r <= ttiab_pkg::RST_BASE_HIGH;
      base_len_r  <= ttiab_pkg::RST_BASE_LEN;
    end else begin
      base_low_r  <= base_low_nxt;
      base_high_r <= base_high_nxt;
      base_len_r  <= base_len_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      alpha[i]     = base_low_r[i*8 +: 8];
      alpha[i + 8] = base_high_r[i*8 +: 8];
    end
  end

  assign used_len = (base_len_r > ttiab_pkg::LEN_W'(MAX_BASE_CHARS))
                    ? ttiab_pkg::LEN_W'(MAX_BASE_CHARS) : base_len_r;

  // Alphabet check: length in range, no control, space, DEL or sign character, and all pairs compared in parallel
  always_comb begin
    base_ok = (base_len_r >= 5'd2) && (base_len_r <= ttiab_pkg::LEN_W'(MAX_BASE_CHARS));
    for (int i = 0; i < MAX_BASE_CHARS; i++) begin
      if (ttiab_pkg::LEN_W'(i) < base_len_r) begin
        if (alpha[i] <= ttiab_pkg::CH_SPACE || alpha[i] == ttiab_pkg::CH_DEL ||
            alpha[i] == ttiab_pkg::CH_PLUS || alpha[i] == ttiab_pkg::CH_MINUS) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE_CHARS; j++) begin
          if (ttiab_pkg::LEN_W'(j) < base_len_r && alpha[j] == alpha[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // Digit lookup; walking down leaves the lowest matching index
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_BASE_CHARS - 1; i >= 0; i--) begin
      if (ttiab_pkg::LEN_W'(i) < used_len && alpha[i] == ch) begin
        hit   = 1'b1;
        digit = ttiab_pkg::DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    push_entry.hit     = hit;
    push_entry.digit   = digit;
    push_entry.len     = base_len_r;
    push_entry.base_ok = base_ok;
    if (ch == ttiab_pkg::CH_NUL) begin
      push_entry.cls = ttiab_pkg::CLS_NUL;
    end else if ((ch >= ttiab_pkg::CH_TAB && ch <= ttiab_pkg::CH_CR) ||
                 ch == ttiab_pkg::CH_SPACE) begin
      push_entry.cls = ttiab_pkg::CLS_WS;
    end else if (ch == ttiab_pkg::CH_PLUS) begin
      push_entry.cls = ttiab_pkg::CLS_PLUS;
    end else if (ch == ttiab_pkg::CH_MINUS) begin
      push_entry.cls = ttiab_pkg::CLS_MINUS;
    end else if (hit) begin
      push_entry.cls = ttiab_pkg::CLS_DIGIT;
    end else begin
      push_entry.cls = ttiab_pkg::CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

/* design/ttiab_queue.sv */
// ttiab_queue: two-entry queue of classified characters between front and back.
// Depends on ttiab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttiab_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  ttiab_pkg::entry_t       push_entry,
  output logic                    full,
  input  wire logic               pop,
  output ttiab_pkg::entry_t       pop_entry,
  output logic                    not_empty
);

  ttiab_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* design/ttiab_back.sv */
// ttiab_back: parse sequencer, multiply-add accumulator and result register.
// Depends on ttiab_pkg and ttiab_if.
`timescale 1ns / 1ps
`default_nettype none

module ttiab_back #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  ttiab_pkg::entry_t       q_entry,
  output logic                    pop,
  ttiab_out_if.source             out_chan
);

  ttiab_pkg::phase_t phase_r, phase_nxt;
  logic                  sign_r, sign_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                  out_ok_r, out_ok_nxt;

  logic                                  is_nul;
  logic [VALUE_BITS+ttiab_pkg::LEN_W-1:0] prod;
  logic [VALUE_BITS-1:0]                 mac;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.value   = out_value_r;
  assign out_chan.base_ok = out_ok_r;

  always_comb begin
    is_nul = (q_entry.cls == ttiab_pkg::CLS_NUL);
    // only an end of string needs room in the result register
    pop    = q_valid && (!is_nul || !out_valid_r || out_chan.ready);
    prod   = {{ttiab_pkg::LEN_W{1'b0}}, acc_r} *
             {{VALUE_BITS{1'b0}}, q_entry.len};
    mac    = prod[VALUE_BITS-1:0] +
             {{(VALUE_BITS-ttiab_pkg::DIGIT_W){1'b0}}, q_entry.digit};

    phase_nxt     = phase_r;
    sign_nxt      = sign_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;

    if (pop) begin
      if (is_nul) begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = q_entry.base_ok;
        out_value_nxt = !q_entry.base_ok ? '0 : (sign_r ? (~acc_r + 1'b1) : acc_r);
        phase_nxt     = ttiab_pkg::PH_WS;
        sign_nxt      = 1'b0;
        acc_nxt       = '0;
      end else begin
        case (phase_r)
          ttiab_pkg::PH_WS, ttiab_pkg::PH_SIGN: begin
            if (!(phase_r == ttiab_pkg::PH_WS && q_entry.cls == ttiab_pkg::CLS_WS)) begin
              case (q_entry.cls)
                ttiab_pkg::CLS_PLUS: begin
                  phase_nxt = ttiab_pkg::PH_SIGN;
                end
                ttiab_pkg::CLS_MINUS: begin
                  phase_nxt = ttiab_pkg::PH_SIGN;
                  sign_nxt  = !sign_r;
                end
                ttiab_pkg::CLS_DIGIT: begin
                  phase_nxt = ttiab_pkg::PH_DIGIT;
                  acc_nxt   = mac;
                end
                default: begin
                  // an invalid alphabet may hold whitespace, which then counts
                  if (q_entry.hit) begin
                    phase_nxt = ttiab_pkg::PH_DIGIT;
                    acc_nxt   = mac;
                  end else begin
                    phase_nxt = ttiab_pkg::PH_DONE;
                  end
                end
              endcase
            end
          end
          ttiab_pkg::PH_DIGIT: begin
            // signs and whitespace are digits too when the alphabet holds them
            if (q_entry.hit) begin
              acc_nxt = mac;
            end else begin
              phase_nxt = ttiab_pkg::PH_DONE;
            end
          end
          ttiab_pkg::PH_DONE: ;
          default: phase_nxt = ttiab_pkg::PH_WS;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ttiab_pkg::PH_WS;
      sign_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sign_r      <= sign_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_value_r == '0))
    else $error("invalid alphabet gave a nonzero value");

  a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_nul) |=> (phase_r == ttiab_pkg::PH_WS && !sign_r && acc_r == '0))
    else $error("parse state not cleared after end of string");

endmodule

`default_nettype wire

/* design/text_to_integer_any_base_unit.sv */
// text_to_integer_any_base_unit: top level of the string-to-integer converter
// with a configurable digit alphabet. Depends on ttiab_pkg, ttiab_if,
// ttiab_front, ttiab_queue and ttiab_back.
//
//   channel    dir  handshake     payload
//   in_chan    in   valid/ready   ch (8)           one character, NUL ends string
//   out_chan   out  valid/ready   value (VALUE_BITS, signed), base_ok (1)
//   cfg_chan   in   valid/ready   index (2), data (64) register write
//
// Cycles: one character per cycle, unless the queue fills behind a held result;
// the multiply-add of the accumulator (value times alphabet length plus digit)
// is done in the back end. A NUL taken in is written into the queue, then, with
// the result register free, popped from it and loaded into the result register.
// Reset: synchronous, active low; clears the queue, parse state and result valid
// flag and loads the decimal alphabet "0123456789".
// Stalls: a held result blocks only the next NUL in the back end; other
// characters keep draining, and the two-entry queue lets the input side run
// on while the back end waits.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_any_base_unit #(
  parameter int MAX_BASE_CHARS = 16,
  parameter int VALUE_BITS     = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ttiab_in_if.sink    in_chan,
  ttiab_out_if.source out_chan,
  ttiab_cfg_if.sink   cfg_chan
);

  // front to queue
  logic              push;
  ttiab_pkg::entry_t push_entry;
  logic              q_full;

  // queue to back
  logic              pop;
  ttiab_pkg::entry_t pop_entry;
  logic              q_valid;

  // Front: alphabet registers, character class, digit index and the
  // alphabet check, all taken with the configuration of the moment.
  ttiab_front #(
    .MAX_BASE_CHARS (MAX_BASE_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue decouples classification from the parse sequencer.
  ttiab_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid)
  );

  // Back: whitespace / sign / digit phases, accumulator, result register.
  ttiab_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (pop_entry),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
